// ----- sv/orderbook_vwap_arbitrage_scan_assert.svh -----
// ----------------------------------------------------------------------------
// Scanner assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ORDERBOOK_VWAP_ARBITRAGE_SCAN_ASSERT_SVH
`define ORDERBOOK_VWAP_ARBITRAGE_SCAN_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scan check failed");

// next-cycle implication, checked out of reset
`define OVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scan check failed");

`endif

// ----- sv/obvwap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obvwap_pkg
// Widths, codes and the shared arithmetic unit's request/response types.
// ----------------------------------------------------------------------------
package obvwap_pkg;

    localparam int QW = 40;         // quantity
    localparam int PW = 32;         // price / vwap
    localparam int CW = 77;         // cumulative cost, room for 32 levels
    localparam int AW = 136;        // unit accumulator, holds net * qty * vwap
    localparam int RW = 76;         // min_profit * scale
    localparam int CFW = 48;        // config data

    localparam logic [63:0] SCALE = 64'd100000000;

    localparam logic [7:0] NB_SCALE = 8'd27;
    localparam logic [7:0] NB_QTY   = 8'd40;
    localparam logic [7:0] NB_PRICE = 8'd32;
    localparam logic [7:0] NB_COST  = 8'd77;
    localparam logic [7:0] NB_GROSS = 8'd59;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_DEPTH = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_MAXQ   = 3'd1;
    localparam logic [2:0] CFG_MINP   = 3'd2;
    localparam logic [2:0] CFG_FEE0   = 3'd3;
    localparam logic [2:0] CFG_FEE1   = 3'd4;
    localparam logic [2:0] CFG_FEE2   = 3'd5;
    localparam logic [2:0] CFG_FEE3   = 3'd6;

    typedef struct packed {
        logic          start;
        logic          is_div;
        logic [7:0]    nbits;
        logic [AW-1:0] a;       // multiplicand or dividend
        logic [63:0]   b;       // multiplier or divisor
    } t_alu_req;

    typedef struct packed {
        logic          done;
        logic [AW-1:0] acc;     // product
        logic [63:0]   q;       // quotient
        logic          rem_nz;
    } t_alu_rsp;

endpackage

// ----- sv/obvwap_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obvwap_alu
// Bit-serial shift-add multiplier and restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module obvwap_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  obvwap_pkg::t_alu_req i_req,
    output obvwap_pkg::t_alu_rsp o_rsp
);
    import obvwap_pkg::*;

    logic          r_busy, r_done, r_div;
    logic [7:0]    r_cnt;
    logic [AW-1:0] r_a, r_acc;
    logic [63:0]   r_b, r_q;
    logic [QW-1:0] r_d, r_rem;

    logic [7:0]    idx;
    logic          bit_in, ge;
    logic [QW:0]   rem_sh, rem_new;
    logic [AW-1:0] acc_new;

    always_comb begin
        idx     = r_cnt - 8'd1;
        bit_in  = r_div ? r_a[idx] : r_b[idx[5:0]];
        rem_sh  = {r_rem, bit_in};
        ge      = rem_sh >= {1'b0, r_d};
        rem_new = ge ? rem_sh - {1'b0, r_d} : rem_sh;
        acc_new = {r_acc[AW-2:0], 1'b0} + (bit_in ? r_a : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 8'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.is_div;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_d   <= i_req.b[QW-1:0];
            r_acc <= '0;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= rem_new[QW-1:0];
                r_q   <= {r_q[62:0], ge};
            end else begin
                r_acc <= acc_new;
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.acc    = r_acc;
    assign o_rsp.q      = r_q;
    assign o_rsp.rem_nz = (r_rem != '0);

endmodule

// ----- sv/obvwap_book.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obvwap_book
// Level store: price and quantity per entry, registered read, valid bits.
// ----------------------------------------------------------------------------
module obvwap_book #(
    parameter int DEPTH = 64,
    parameter int MAW   = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [MAW-1:0]           i_wr_addr,
    input  logic [obvwap_pkg::PW-1:0] i_wr_price,
    input  logic [obvwap_pkg::QW-1:0] i_wr_qty,
    input  logic                     i_rd_en,
    input  logic [MAW-1:0]           i_rd_addr,
    output logic [obvwap_pkg::PW-1:0] o_rd_price,
    output logic [obvwap_pkg::QW-1:0] o_rd_qty
);
    import obvwap_pkg::*;

    logic [PW+QW-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [PW+QW-1:0] r_rd;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_price, i_wr_qty};
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign o_rd_price = r_rd_vld ? r_rd[PW+QW-1:QW] : '0;
    assign o_rd_qty   = r_rd_vld ? r_rd[QW-1:0] : '0;

endmodule

// ----- sv/orderbook_vwap_arbitrage_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orderbook_vwap_arbitrage_scan
// Per-exchange book store and a sequenced VWAP merge scan over one pair.
// ----------------------------------------------------------------------------
// Level writes and depth writes keep busy low. An evaluate beat raises busy
// while the unit works out the profit floor, while each book level on either
// side is accumulated and while each merge step runs. Every product and
// every quotient goes through the one bit-serial multiply/divide unit a bit at
// a time. Results come as one-cycle o_valid strobes the receiver cannot hold
// off; the run always ends with a terminator beat (o_last high), during which
// busy is already low.
// ----------------------------------------------------------------------------
module orderbook_vwap_arbitrage_scan #(
    parameter int EXCHANGES = 4,
    parameter int LEVELS    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_idx,
    input  logic [obvwap_pkg::CFW-1:0] i_cfg_data,
    input  logic [1:0]                i_op,
    input  logic [1:0]                i_exchange,
    input  logic [1:0]                i_sell_side_exchange,
    input  logic                      i_side,
    input  logic [2:0]                i_level,
    input  logic [31:0]               i_price,
    input  logic [39:0]               i_quantity,
    input  logic [3:0]                i_depth,
    output logic                      o_valid,
    output logic                      o_is_opportunity,
    output logic [1:0]                o_buy_exchange,
    output logic [1:0]                o_sell_exchange,
    output logic [3:0]                o_buy_levels,
    output logic [3:0]                o_sell_levels,
    output logic [31:0]               o_buy_vwap,
    output logic [31:0]               o_sell_vwap,
    output logic signed [39:0]        o_net_pct,
    output logic [39:0]               o_common_qty,
    output logic                      o_last
);
    import obvwap_pkg::*;

    localparam int NSIDE = EXCHANGES * 2;
    localparam int DEPTH = NSIDE * LEVELS;
    localparam int MAW   = $clog2(DEPTH);
    localparam int SIW   = $clog2(NSIDE);
    localparam int LCW   = $clog2(LEVELS + 1);
    localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_RHS  = 17'h00002,
        S_WAIT = 17'h00004,
        S_RHSD = 17'h00008,
        S_BRD  = 17'h00010,
        S_BDAT = 17'h00020,
        S_BACC = 17'h00040,
        S_MB   = 17'h00080,
        S_MS   = 17'h00100,
        S_MG   = 17'h00200,
        S_MD   = 17'h00400,
        S_MN   = 17'h00800,
        S_MT   = 17'h01000,
        S_M2   = 17'h02000,
        S_MC   = 17'h04000,
        S_ADV  = 17'h08000,
        S_TERM = 17'h10000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;

    // configuration
    logic [3:0]     r_enable;
    logic [QW-1:0]  r_maxq;
    logic [47:0]    r_minp;
    logic [19:0]    r_fee [4];
    logic [LCW-1:0] r_depth [NSIDE];

    // scan state
    logic [1:0]        r_ex, n_ex, r_sx, n_sx;
    logic              r_side, n_side;
    logic [LCW-1:0]    r_lvl, n_lvl, r_n, n_n, r_bn, n_bn, r_sn, n_sn;
    logic [LCW-1:0]    r_bi, n_bi, r_si, n_si;
    logic [QW-1:0]     r_tq, n_tq;
    logic [CW-1:0]     r_tc, n_tc;
    logic [PW-1:0]     r_bv, n_bv, r_sv, n_sv;
    logic              r_ge, n_ge;
    logic signed [63:0] r_net, n_net;
    logic [RW-1:0]     r_rhs, n_rhs;
    logic [QW-1:0]     r_bq [LEVELS], r_sq [LEVELS];
    logic [CW-1:0]     r_bc [LEVELS], r_sc [LEVELS];

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic             accept, wr_en, rd_en, cum_we, emit_rec, emit_term;
    logic [MAW-1:0]   wr_addr, rd_addr;
    logic [PW-1:0]    rd_price;
    logic [QW-1:0]    rd_qty;
    logic [1:0]       cur_ex;
    logic [LCW-1:0]   cur_depth;
    logic [QW-1:0]    room, avail, qb, qs, cq;
    logic [PW-1:0]    diff;
    logic signed [63:0] gross;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign wr_en   = accept && (i_op == OP_WRITE) && (int'(i_exchange) < EXCHANGES)
                     && (int'(i_level) < LEVELS);
    assign wr_addr = MAW'((int'(i_exchange) * 2 + int'(i_side)) * LEVELS + int'(i_level));

    assign cur_ex    = r_side ? r_sx : r_ex;
    assign cur_depth = r_depth[SIW'(int'(cur_ex) * 2 + int'(r_side))];
    assign rd_addr   = MAW'((int'(cur_ex) * 2 + int'(r_side)) * LEVELS + int'(r_lvl));
    assign room      = r_maxq - r_tq;
    assign avail     = (rd_qty < room) ? rd_qty : room;

    assign qb   = r_bq[r_bi[LIW-1:0]];
    assign qs   = r_sq[r_si[LIW-1:0]];
    assign cq   = (qb < qs) ? qb : qs;

    obvwap_book #(
        .DEPTH (DEPTH),
        .MAW   (MAW)
    ) u_book (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_price (i_price),
        .i_wr_qty   (i_quantity),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_price (rd_price),
        .o_rd_qty   (rd_qty)
    );

    obvwap_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_ex      = r_ex;
        n_sx      = r_sx;
        n_side    = r_side;
        n_lvl     = r_lvl;
        n_n       = r_n;
        n_bn      = r_bn;
        n_sn      = r_sn;
        n_bi      = r_bi;
        n_si      = r_si;
        n_tq      = r_tq;
        n_tc      = r_tc;
        n_bv      = r_bv;
        n_sv      = r_sv;
        n_ge      = r_ge;
        n_net     = r_net;
        n_rhs     = r_rhs;
        rd_en     = 1'b0;
        cum_we    = 1'b0;
        emit_rec  = 1'b0;
        emit_term = 1'b0;
        alu_req   = '0;
        diff      = '0;
        gross     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_EVAL)) begin
                    n_ex    = i_exchange;
                    n_sx    = i_sell_side_exchange;
                    n_state = S_RHS;
                end
            end
            S_RHS: begin
                alu_req.start = 1'b1;
                alu_req.nbits = NB_SCALE;
                alu_req.a     = AW'(r_minp);
                alu_req.b     = SCALE;
                n_ret         = S_RHSD;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = r_ret;
                end
            end
            S_RHSD: begin
                n_rhs  = alu_rsp.acc[RW-1:0];
                n_side = 1'b0;
                n_lvl  = '0;
                n_n    = '0;
                n_tq   = '0;
                n_tc   = '0;
                n_bn   = '0;
                n_sn   = '0;
                n_bi   = '0;
                n_si   = '0;
                if ((int'(r_ex) < EXCHANGES) && (int'(r_sx) < EXCHANGES)
                    && r_enable[r_ex] && r_enable[r_sx]) begin
                    n_state = S_BRD;
                end else begin
                    n_state = S_TERM;
                end
            end
            S_BRD: begin
                if ((r_lvl < cur_depth) && (r_tq < r_maxq)) begin
                    rd_en   = 1'b1;
                    n_state = S_BDAT;
                end else if (!r_side) begin
                    n_bn   = r_n;
                    n_side = 1'b1;
                    n_lvl  = '0;
                    n_n    = '0;
                    n_tq   = '0;
                    n_tc   = '0;
                    if (r_n == '0) begin
                        n_state = S_TERM;
                    end
                end else begin
                    n_sn    = r_n;
                    n_state = S_MB;
                end
            end
            S_BDAT: begin
                alu_req.start = 1'b1;
                alu_req.nbits = NB_QTY;
                alu_req.a     = AW'(rd_price);
                alu_req.b     = 64'(avail);
                n_ret         = S_BACC;
                n_state       = S_WAIT;
            end
            S_BACC: begin
                n_tq    = r_tq + avail;
                n_tc    = r_tc + alu_rsp.acc[CW-1:0];
                cum_we  = 1'b1;
                n_n     = r_n + 1'b1;
                n_lvl   = r_lvl + 1'b1;
                n_state = S_BRD;
            end
            S_MB: begin
                if ((r_bi < r_bn) && (r_si < r_sn)) begin
                    if ((qb != '0) && (qs != '0)) begin
                        alu_req.start  = 1'b1;
                        alu_req.is_div = 1'b1;
                        alu_req.nbits  = NB_COST;
                        alu_req.a      = AW'(r_bc[r_bi[LIW-1:0]]);
                        alu_req.b      = 64'(qb);
                        n_ret          = S_MS;
                        n_state        = S_WAIT;
                    end else begin
                        n_state = S_ADV;
                    end
                end else begin
                    n_state = S_TERM;
                end
            end
            S_MS: begin
                n_bv           = alu_rsp.q[PW-1:0];
                alu_req.start  = 1'b1;
                alu_req.is_div = 1'b1;
                alu_req.nbits  = NB_COST;
                alu_req.a      = AW'(r_sc[r_si[LIW-1:0]]);
                alu_req.b      = 64'(qs);
                n_ret          = S_MG;
                n_state        = S_WAIT;
            end
            S_MG: begin
                n_sv = alu_rsp.q[PW-1:0];
                n_ge = (n_sv >= r_bv);
                diff = n_ge ? n_sv - r_bv : r_bv - n_sv;
                if (r_bv == '0) begin
                    n_state = S_ADV;
                end else begin
                    alu_req.start = 1'b1;
                    alu_req.nbits = NB_SCALE;
                    alu_req.a     = AW'(diff);
                    alu_req.b     = SCALE;
                    n_ret         = S_MD;
                    n_state       = S_WAIT;
                end
            end
            S_MD: begin
                alu_req.start  = 1'b1;
                alu_req.is_div = 1'b1;
                alu_req.nbits  = NB_GROSS;
                alu_req.a      = alu_rsp.acc;
                alu_req.b      = 64'(r_bv);
                n_ret          = S_MN;
                n_state        = S_WAIT;
            end
            S_MN: begin
                // a short fall rounds away from zero (ceiling of the magnitude)
                if (r_ge) begin
                    gross = $signed(alu_rsp.q);
                end else begin
                    gross = -($signed(alu_rsp.q) + (alu_rsp.rem_nz ? 64'sd1 : 64'sd0));
                end
                n_net   = gross - $signed(64'(r_fee[r_ex])) - $signed(64'(r_fee[r_sx]));
                n_state = S_MT;
            end
            S_MT: begin
                if (r_net < 0) begin
                    n_state = S_ADV;
                end else if (r_net == 0) begin
                    emit_rec = (r_minp == '0);
                    n_state  = S_ADV;
                end else begin
                    alu_req.start = 1'b1;
                    alu_req.nbits = NB_QTY;
                    alu_req.a     = AW'(unsigned'(r_net));
                    alu_req.b     = 64'(cq);
                    n_ret         = S_M2;
                    n_state       = S_WAIT;
                end
            end
            S_M2: begin
                alu_req.start = 1'b1;
                alu_req.nbits = NB_PRICE;
                alu_req.a     = alu_rsp.acc;
                alu_req.b     = 64'(r_bv);
                n_ret         = S_MC;
                n_state       = S_WAIT;
            end
            S_MC: begin
                emit_rec = (alu_rsp.acc >= AW'(r_rhs));
                n_state  = S_ADV;
            end
            S_ADV: begin
                if (qb < qs) begin
                    n_bi = r_bi + 1'b1;
                end else begin
                    n_si = r_si + 1'b1;
                end
                n_state = S_MB;
            end
            S_TERM: begin
                emit_term = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_enable <= 4'hF;
            r_maxq   <= QW'(100000000);
            r_minp   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_fee[i] <= '0;
            end
            for (int i = 0; i < NSIDE; i++) begin
                r_depth[i] <= '0;
            end
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            o_valid <= emit_rec || emit_term;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE: r_enable <= i_cfg_data[3:0];
                    CFG_MAXQ:   r_maxq   <= i_cfg_data[QW-1:0];
                    CFG_MINP:   r_minp   <= i_cfg_data[47:0];
                    CFG_FEE0:   r_fee[0] <= i_cfg_data[19:0];
                    CFG_FEE1:   r_fee[1] <= i_cfg_data[19:0];
                    CFG_FEE2:   r_fee[2] <= i_cfg_data[19:0];
                    CFG_FEE3:   r_fee[3] <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (accept && (i_op == OP_DEPTH) && (int'(i_exchange) < EXCHANGES)) begin
                r_depth[SIW'(int'(i_exchange) * 2 + int'(i_side))] <=
                    (int'(i_depth) > LEVELS) ? LCW'(LEVELS) : LCW'(i_depth);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex   <= n_ex;
        r_sx   <= n_sx;
        r_side <= n_side;
        r_lvl  <= n_lvl;
        r_n    <= n_n;
        r_bn   <= n_bn;
        r_sn   <= n_sn;
        r_bi   <= n_bi;
        r_si   <= n_si;
        r_tq   <= n_tq;
        r_tc   <= n_tc;
        r_bv   <= n_bv;
        r_sv   <= n_sv;
        r_ge   <= n_ge;
        r_net  <= n_net;
        r_rhs  <= n_rhs;
        if (cum_we) begin
            if (!r_side) begin
                r_bq[r_n[LIW-1:0]] <= n_tq;
                r_bc[r_n[LIW-1:0]] <= n_tc;
            end else begin
                r_sq[r_n[LIW-1:0]] <= n_tq;
                r_sc[r_n[LIW-1:0]] <= n_tc;
            end
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (emit_rec) begin
            o_is_opportunity <= 1'b1;
            o_buy_exchange   <= r_ex;
            o_sell_exchange  <= r_sx;
            o_buy_levels     <= 4'(r_bi + 1'b1);
            o_sell_levels    <= 4'(r_si + 1'b1);
            o_buy_vwap       <= r_bv;
            o_sell_vwap      <= r_sv;
            if (r_net > 64'sd549755813887) begin
                o_net_pct <= 40'sh7F_FFFF_FFFF;
            end else if (r_net < -64'sd549755813888) begin
                o_net_pct <= 40'sh80_0000_0000;
            end else begin
                o_net_pct <= r_net[39:0];
            end
            o_common_qty     <= cq;
            o_last           <= 1'b0;
        end else if (emit_term) begin
            o_is_opportunity <= 1'b0;
            o_buy_exchange   <= r_ex;
            o_sell_exchange  <= r_sx;
            o_buy_levels     <= '0;
            o_sell_levels    <= '0;
            o_buy_vwap       <= '0;
            o_sell_vwap      <= '0;
            o_net_pct        <= '0;
            o_common_qty     <= '0;
            o_last           <= 1'b1;
        end
    end

`include "orderbook_vwap_arbitrage_scan_assert.svh"

    `OVS_ASSERT_NOW(a_term_not_rec, i_clk, i_rst_n, o_valid && o_last, !o_is_opportunity)
    `OVS_ASSERT_NOW(a_term_ends_run, i_clk, i_rst_n, o_valid && o_last, !busy)
    `OVS_ASSERT_NOW(a_rec_in_run, i_clk, i_rst_n, o_valid && o_is_opportunity, busy)
    `OVS_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, start && !busy && (i_op == OP_EVAL), busy)

endmodule

// ----- tb/sv/orderbook_vwap_arbitrage_scan_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orderbook_vwap_arbitrage_scan_test
// Self-checking bench for the book store and VWAP merge scan. Book writes and
// pair evaluations are driven through the command port, a behavioral scan
// model predicts the records and terminators, and each strobed result beat is
// compared in order. Runs a directed table, then random books over several
// register settings with varying sender idle rates.
// ----------------------------------------------------------------------------
module orderbook_vwap_arbitrage_scan_test;
    import obvwap_pkg::*;

    localparam int  NEX        = 4;
    localparam int  NLV        = 8;
    localparam int  CYCLE_CAP  = 15000000;
    localparam int  N_PHASES   = 6;
    localparam int  PHASE_BEATS = 77;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef logic [191:0] t_wide;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  ex;
        logic [1:0]  sx;
        logic        side;
        logic [2:0]  lvl;
        logic [31:0] price;
        logic [39:0] qty;
        logic [3:0]  depth;
    } t_cmd;

    typedef struct packed {
        logic        fixed;
        t_cmd        cmd;
    } t_dir_row;

    typedef struct packed {
        logic        opp;
        logic [1:0]  bex;
        logic [1:0]  sex;
        logic [3:0]  bl;
        logic [3:0]  sl;
        logic [31:0] bv;
        logic [31:0] sv;
        logic [39:0] net;
        logic [39:0] cq;
        logic        last;
    } t_scan_res;

    logic i_clk, i_rst_n, start, busy;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [CFW-1:0] i_cfg_data;
    logic [1:0] i_op, i_exchange, i_sell_side_exchange;
    logic i_side;
    logic [2:0] i_level;
    logic [31:0] i_price;
    logic [39:0] i_quantity;
    logic [3:0] i_depth;
    logic o_valid, o_is_opportunity, o_last;
    logic [1:0] o_buy_exchange, o_sell_exchange;
    logic [3:0] o_buy_levels, o_sell_levels;
    logic [31:0] o_buy_vwap, o_sell_vwap;
    logic signed [39:0] o_net_pct;
    logic [39:0] o_common_qty;

    orderbook_vwap_arbitrage_scan #(.EXCHANGES(NEX), .LEVELS(NLV)) dut (.*);

    // scan model state
    logic [31:0] book_price [64];
    logic [39:0] book_qty   [64];
    logic [3:0]  book_depth [8];
    logic [3:0]  ex_enable;
    logic [39:0] max_qty;
    logic [47:0] profit_floor;
    logic [19:0] ex_fee [4];

    t_scan_res pending_results[$];
    int errors, n_beats, n_records, n_terms, cycles;
    int idle_pct;
    logic [31:0] base_px;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("%0t timeout with %0d results pending", $time, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void add_expected(input t_scan_res r);
        pending_results = {pending_results, r};
    endfunction

    task automatic accumulate(input logic [1:0] ex, input logic side,
                              output logic [39:0] cq[NLV], output t_wide cc[NLV],
                              output int n);
        logic [39:0] tq, room, avail;
        t_wide tc;
        int d, base;
        tq = '0;
        tc = '0;
        n = 0;
        d = book_depth[{ex, side}];
        base = {ex, side, 3'b000};
        for (int l = 0; l < d && tq < max_qty; l++) begin
            room  = max_qty - tq;
            avail = book_qty[base + l] < room ? book_qty[base + l] : room;
            tq = tq + avail;
            tc = tc + t_wide'(avail) * t_wide'(book_price[base + l]);
            cq[n] = tq;
            cc[n] = tc;
            n++;
        end
    endtask

    task automatic scan_predict(input t_cmd c);
        logic [39:0] bq[NLV], sq[NLV];
        t_wide bc[NLV], sc[NLV];
        t_wide tmp, lhs, rhs;
        logic [39:0] qb, qs, cqm;
        logic [31:0] bv, sv;
        logic [63:0] netu;
        longint gross, net, sat;
        logic ok;
        int bn, sn, bi, si;
        t_scan_res r;
        bn = 0; sn = 0; bi = 0; si = 0;
        case (c.op)
            OP_WRITE: begin
                book_price[{c.ex, c.side, c.lvl}] = c.price;
                book_qty[{c.ex, c.side, c.lvl}]   = c.qty;
            end
            OP_DEPTH: book_depth[{c.ex, c.side}] = c.depth > NLV ? 4'(NLV) : c.depth;
            OP_EVAL: begin
                if (ex_enable[c.ex] && ex_enable[c.sx]) begin
                    accumulate(c.ex, 1'b0, bq, bc, bn);
                    if (bn > 0) accumulate(c.sx, 1'b1, sq, sc, sn);
                end
                while (bi < bn && si < sn) begin
                    qb = bq[bi];
                    qs = sq[si];
                    cqm = qb < qs ? qb : qs;
                    if (qb > 0 && qs > 0) begin
                        tmp = bc[bi] / t_wide'(qb);
                        bv = tmp[31:0];
                        tmp = sc[si] / t_wide'(qs);
                        sv = tmp[31:0];
                        if (bv > 0) begin
                            if (sv >= bv)
                                gross = longint'(((64'(sv) - 64'(bv)) * SCALE) / 64'(bv));
                            else
                                gross = -longint'(((64'(bv) - 64'(sv)) * SCALE
                                                   + 64'(bv) - 64'd1) / 64'(bv));
                            net = gross - longint'(64'(ex_fee[c.ex]))
                                        - longint'(64'(ex_fee[c.sx]));
                            if (net < 0) ok = 1'b0;
                            else if (net == 0) ok = (profit_floor == 0);
                            else begin
                                netu = net;
                                lhs = t_wide'(netu) * t_wide'(cqm) * t_wide'(bv);
                                rhs = t_wide'(profit_floor) * t_wide'(SCALE);
                                ok = lhs >= rhs;
                            end
                            if (ok) begin
                                sat = net;
                                if (sat > 64'sd549755813887) sat = 64'sd549755813887;
                                r = '{1'b1, c.ex, c.sx, 4'(bi + 1), 4'(si + 1), bv, sv,
                                      sat[39:0], cqm, 1'b0};
                                add_expected(r);
                            end
                        end
                    end
                    if (qb < qs) bi++;
                    else si++;
                end
                add_expected('{1'b0, c.ex, c.sx, 4'd0, 4'd0, 32'd0, 32'd0,
                               40'd0, 40'd0, 1'b1});
            end
            default: ;
        endcase
    endtask

    // called at a rising edge; returns at the edge the beat is taken
    task automatic send_cmd(input t_cmd c, input logic fixed);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= c.op;
        i_exchange <= c.ex;
        i_sell_side_exchange <= c.sx;
        i_side <= c.side;
        i_level <= c.lvl;
        i_price <= c.price;
        i_quantity <= c.qty;
        i_depth <= c.depth;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_beats++;
        if (fixed)
            add_expected('{1'b0, c.ex, c.sx, 4'd0, 4'd0, 32'd0, 32'd0,
                           40'd0, 40'd0, 1'b1});
        else
            scan_predict(c);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() > 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [CFW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLE: ex_enable = data[3:0];
            CFG_MAXQ:   max_qty = data[39:0];
            CFG_MINP:   profit_floor = data[47:0];
            CFG_FEE0:   ex_fee[0] = data[19:0];
            CFG_FEE1:   ex_fee[1] = data[19:0];
            CFG_FEE2:   ex_fee[2] = data[19:0];
            CFG_FEE3:   ex_fee[3] = data[19:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_price();
        if ($urandom_range(99) < 5) return $urandom;
        return base_px + 32'($urandom_range(0, 120)) - 32'd30;
    endfunction

    function automatic logic [39:0] rand_qty();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(99) < 5) return raw[39:0];
        if ($urandom_range(99) < 5) return '0;
        return 40'($urandom_range(0, 150000000));
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        logic [95:0] noise;
        int pick;
        noise = {$urandom, $urandom, $urandom};
        c = noise[$bits(t_cmd)-1:0];
        pick = $urandom_range(99);
        if (pick < 5) return c;  // raw noise, any op
        c.price = rand_price();
        c.qty = rand_qty();
        if (pick < 50) c.op = OP_WRITE;
        else if (pick < 65) begin
            c.op = OP_DEPTH;
            c.depth = $urandom_range(99) < 10 ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, NLV));
        end else if (pick < 95) c.op = OP_EVAL;
        else c.op = OP_NONE;
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_scan_res got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_is_opportunity, o_buy_exchange, o_sell_exchange, o_buy_levels,
                    o_sell_levels, o_buy_vwap, o_sell_vwap, o_net_pct, o_common_qty, o_last};
            if (got.last) n_terms++;
            else n_records++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result beat %p", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.opp !== want.opp || got.bex !== want.bex || got.sex !== want.sex ||
                    got.bl !== want.bl || got.sl !== want.sl || got.bv !== want.bv ||
                    got.sv !== want.sv || got.net !== want.net || got.cq !== want.cq ||
                    got.last !== want.last) begin
                    errors++;
                    $display("%0t mismatch expected %p", $time, want);
                    $display("%0t          actual   %p", $time, got);
                end
            end
        end
    end

    t_dir_row dir_rows[16];
    logic [CFW-1:0] cfg_vals[7];
    int idle_sel[N_PHASES] = '{0, 66, 27, 66, 0, 27};

    initial begin
        errors = 0; n_beats = 0; n_records = 0; n_terms = 0; cycles = 0;
        idle_pct = 0;
        base_px = 32'd10000;
        for (int k = 0; k < 64; k++) begin
            book_price[k] = '0;
            book_qty[k] = '0;
        end
        for (int k = 0; k < 8; k++) book_depth[k] = '0;
        ex_enable = 4'hF; max_qty = 40'd100000000; profit_floor = '0;
        for (int k = 0; k < 4; k++) ex_fee[k] = '0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cfg_we <= 1'b0; i_cfg_idx <= '0; i_cfg_data <= '0;
        i_op <= '0; i_exchange <= '0; i_sell_side_exchange <= '0; i_side <= 1'b0;
        i_level <= '0; i_price <= '0; i_quantity <= '0; i_depth <= '0;

        //          fixed op        ex    sx    side  lvl   price         qty        depth
        dir_rows[0]  = '{1'b1, '{OP_EVAL,  2'd0, 2'd1, 1'b0, 3'd0, 32'd0, 40'd0, 4'd0}};
        dir_rows[1]  = '{1'b0, '{OP_NONE,  2'd3, 2'd3, 1'b1, 3'd7, 32'hFFFFFFFF,
                                 40'hFF_FFFF_FFFF, 4'hF}};
        dir_rows[2]  = '{1'b0, '{OP_WRITE, 2'd0, 2'd0, 1'b0, 3'd0, 32'd10000,
                                 40'd50000000, 4'd0}};
        dir_rows[3]  = '{1'b0, '{OP_WRITE, 2'd0, 2'd0, 1'b0, 3'd1, 32'd10010,
                                 40'd80000000, 4'd0}};
        dir_rows[4]  = '{1'b0, '{OP_DEPTH, 2'd0, 2'd0, 1'b0, 3'd0, 32'd0, 40'd0, 4'd2}};
        dir_rows[5]  = '{1'b0, '{OP_WRITE, 2'd1, 2'd0, 1'b1, 3'd0, 32'd10100,
                                 40'd30000000, 4'd0}};
        dir_rows[6]  = '{1'b0, '{OP_WRITE, 2'd1, 2'd0, 1'b1, 3'd1, 32'd10050,
                                 40'd90000000, 4'd0}};
        // depth above the level count saturates
        dir_rows[7]  = '{1'b0, '{OP_DEPTH, 2'd1, 2'd0, 1'b1, 3'd0, 32'd0, 40'd0, 4'hF}};
        dir_rows[8]  = '{1'b0, '{OP_EVAL,  2'd0, 2'd1, 1'b0, 3'd0, 32'd0, 40'd0, 4'd0}};
        // ex1 has no asks: terminator only
        dir_rows[9]  = '{1'b1, '{OP_EVAL,  2'd1, 2'd0, 1'b0, 3'd0, 32'd0, 40'd0, 4'd0}};
        dir_rows[10] = '{1'b0, '{OP_WRITE, 2'd2, 2'd0, 1'b0, 3'd7, 32'hFFFFFFFF,
                                 40'hFF_FFFF_FFFF, 4'd0}};
        dir_rows[11] = '{1'b0, '{OP_DEPTH, 2'd2, 2'd0, 1'b0, 3'd0, 32'd0, 40'd0, 4'd8}};
        dir_rows[12] = '{1'b0, '{OP_WRITE, 2'd3, 2'd0, 1'b1, 3'd0, 32'hFFFFFFFF,
                                 40'hFF_FFFF_FFFF, 4'd0}};
        dir_rows[13] = '{1'b0, '{OP_DEPTH, 2'd3, 2'd0, 1'b1, 3'd0, 32'd0, 40'd0, 4'd1}};
        dir_rows[14] = '{1'b0, '{OP_EVAL,  2'd2, 2'd3, 1'b0, 3'd0, 32'd0, 40'd0, 4'd0}};
        dir_rows[15] = '{1'b0, '{OP_EVAL,  2'd0, 2'd0, 1'b0, 3'd0, 32'd0, 40'd0, 4'd0}};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send_cmd(dir_rows[k].cmd, dir_rows[k].fixed);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: cfg_vals = '{4'hF, 40'd100000000, 48'd0, 20'd0, 20'd0, 20'd0, 20'd0};
                1: cfg_vals = '{4'hF, 40'hFF_FFFF_FFFF, 48'd0, 20'd1000, 20'd0,
                                20'd2500, 20'd500};
                2: cfg_vals = '{4'($urandom), 40'd200000000, 48'($urandom_range(0, 1 << 20)),
                                20'($urandom_range(0, 3000)), 20'($urandom_range(0, 3000)),
                                20'($urandom_range(0, 3000)), 20'($urandom_range(0, 3000))};
                3: cfg_vals = '{4'h0, 40'd0, 48'hFFFF_FFFF_FFFF, 20'd1000000, 20'd1000000,
                                20'd1000000, 20'd1000000};
                4: cfg_vals = '{4'hF, 40'd0, 48'd0, 20'd0, 20'd0, 20'd0, 20'd0};
                default: cfg_vals = '{4'b1011, 40'd60000000, 48'd1000000, 20'd200,
                                      20'd0, 20'd100, 20'd1000000};
            endcase
            // zero order cap builds no levels: keep it short
            if (ph == 4) cfg_vals[1] = 48'($urandom_range(0, 1)) * 48'd75000000;
            for (int k = 0; k < 7; k++) cfg_write(3'(k), cfg_vals[k]);
            i_cfg_we <= 1'b0;
            idle_pct = idle_sel[ph];
            base_px = $urandom_range(100, 2000000);
            for (int k = 0; k < PHASE_BEATS; k++) send_cmd(rand_cmd(), 1'b0);
            drain();
        end

        $display("%0d command beats, %0d opportunity records, %0d terminators checked",
                 n_beats, n_records, n_terms);
        $display("%0d register settings with sender idle rates 0/27/66 percent", N_PHASES);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t %0d expected results never arrived", $time, pending_results.size());
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
